// ===== rtl/tmt_pkg.sv =====
// shared types, constants and step functions of the tinymt32 generator
package tmt_pkg;

  typedef enum logic [1:0] {
    OP_DRAW = 2'd0,
    OP_PEEK = 2'd1,
    OP_SEED = 2'd2,
    OP_LOAD = 2'd3
  } op_e;

  typedef struct packed {
    logic [31:0] w3;
    logic [31:0] w2;
    logic [31:0] w1;
    logic [31:0] w0;
  } gen_state_t;

  localparam logic [31:0] TM_MASK = 32'h7fff_ffff;
  localparam logic [31:0] TM_MAT1 = 32'h8f70_11ee;
  localparam logic [31:0] TM_MAT2 = 32'hfc78_ff1f;
  localparam logic [31:0] TM_TMAT = 32'h3793_fdff;
  localparam logic [31:0] TM_MULT = 32'd1812433253;

  localparam int unsigned InWidth   = 162;
  localparam int unsigned InBytes   = (InWidth + 7) / 8;
  localparam int unsigned OutWidth  = 64;
  localparam int unsigned OutBytes  = (OutWidth + 7) / 8;
  localparam int unsigned StepWidth = 3;
  localparam logic [StepWidth-1:0] StepLast = 3'd7;

  // one state transition
  function automatic gen_state_t advance(input gen_state_t s);
    logic [31:0] x;
    logic [31:0] y;
    gen_state_t  n;
    x = (s.w0 & TM_MASK) ^ s.w1 ^ s.w2;
    x = x ^ (x << 1);
    y = s.w3 ^ (s.w3 >> 1) ^ x;
    n.w0 = s.w1;
    n.w1 = s.w2 ^ (y[0] ? TM_MAT1 : 32'd0);
    n.w2 = x ^ (y << 10) ^ (y[0] ? TM_MAT2 : 32'd0);
    n.w3 = y;
    return n;
  endfunction

  // tempered output word of a state
  function automatic logic [31:0] temper(input gen_state_t s);
    logic [31:0] t1;
    t1 = s.w0 + (s.w2 >> 8);
    return s.w3 ^ t1 ^ (t1[0] ? TM_TMAT : 32'd0);
  endfunction

endpackage

// ===== rtl/tinymt32_generator_unit.sv =====
// tinymt32 generator with draw, peek, seed and load requests
//
// Input channel s_axis: one request per transfer, op selects draw, peek,
// seed from word_a, or load of four state words; range_max scales the result.
// Output channel m_axis: exactly one result per request, the tempered word
// of the state after the request and that word times range_max shifted
// right by 32.
// A draw, peek or load result goes through these steps after acceptance:
// state update at the accepting edge, temper, one pass through the shared
// 32x32 multiplier, then the output register. A seed runs seven init steps
// through the same multiplier, eight advances, then temper, scale and
// output. s_axis_tready_o is high only while no request is in work, so a
// new request is not taken until the last one has reached the output
// register.
// The result sits in an output register; a new request is accepted while it
// waits, and its result is held back until the old one has been taken.
// Reset clears the state to all zeros (which draws and tempers to zero)
// and empties the output register.
module tinymt32_generator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // op[1:0], word_a[33:2], word_b[65:34], word_c[97:66], word_d[129:98],
  // range_max[161:130], zero fill above
  input  logic [tmt_pkg::InBytes*8-1:0]      s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // random_word[31:0], scaled_value[63:32]
  output logic [tmt_pkg::OutBytes*8-1:0]     m_axis_tdata_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_XOR,
    ST_ADVANCE,
    ST_TEMPER,
    ST_SCALE,
    ST_DONE
  } state_e;

  state_e                           state_q;
  tmt_pkg::gen_state_t              gen_q;
  logic [tmt_pkg::StepWidth-1:0]    step_q;
  logic [31:0]                      word_q;
  logic [31:0]                      rmax_q;
  logic [63:0]                      prod_q;
  logic                             m_valid_q;
  logic [tmt_pkg::OutBytes*8-1:0]   m_data_q;

  tmt_pkg::op_e  in_op;
  logic [31:0]   in_word_a;
  logic [31:0]   in_word_b;
  logic [31:0]   in_word_c;
  logic [31:0]   in_word_d;
  logic [31:0]   in_rmax;
  logic          in_accept;

  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   mul_p;
  logic [31:0]   seed_p;
  logic [31:0]   seed_v;
  logic          out_free;

  assign in_op     = tmt_pkg::op_e'(s_axis_tdata_i[1:0]);
  assign in_word_a = s_axis_tdata_i[33:2];
  assign in_word_b = s_axis_tdata_i[65:34];
  assign in_word_c = s_axis_tdata_i[97:66];
  assign in_word_d = s_axis_tdata_i[129:98];
  assign in_rmax   = s_axis_tdata_i[161:130];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // during seeding the words are kept rotated so the previous word is w0
  // and the word being updated is w1
  assign seed_p = gen_q.w0;
  assign seed_v = {29'd0, step_q} + prod_q[31:0];

  // shared multiplier: init step product while seeding, scaling otherwise
  always_comb begin
    if (state_q == ST_SEED_MUL) begin
      mul_a = tmt_pkg::TM_MULT;
      mul_b = seed_p ^ (seed_p >> 30);
    end else begin
      mul_a = word_q;
      mul_b = rmax_q;
    end
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      gen_q     <= '0;
      step_q    <= '0;
      word_q    <= '0;
      rmax_q    <= '0;
      prod_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // in ST_DONE the output register is refilled or kept, never cleared
      if (m_valid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            rmax_q <= in_rmax;
            unique case (in_op)
              tmt_pkg::OP_DRAW: begin
                gen_q   <= tmt_pkg::advance(gen_q);
                state_q <= ST_TEMPER;
              end
              tmt_pkg::OP_PEEK: begin
                state_q <= ST_TEMPER;
              end
              tmt_pkg::OP_SEED: begin
                gen_q.w0 <= in_word_a;
                gen_q.w1 <= tmt_pkg::TM_MAT1;
                gen_q.w2 <= tmt_pkg::TM_MAT2;
                gen_q.w3 <= tmt_pkg::TM_TMAT;
                step_q   <= 3'd1;
                state_q  <= ST_SEED_MUL;
              end
              tmt_pkg::OP_LOAD: begin
                gen_q.w0 <= in_word_a;
                gen_q.w1 <= in_word_b;
                gen_q.w2 <= in_word_c;
                gen_q.w3 <= in_word_d;
                state_q  <= ST_TEMPER;
              end
              default: begin
                state_q <= ST_TEMPER;
              end
            endcase
          end
        end
        ST_SEED_MUL: begin
          prod_q  <= mul_p;
          state_q <= ST_SEED_XOR;
        end
        ST_SEED_XOR: begin
          if (step_q == tmt_pkg::StepLast) begin
            // last step also undoes the rotation
            gen_q.w0 <= gen_q.w2;
            gen_q.w1 <= gen_q.w3;
            gen_q.w2 <= gen_q.w0;
            gen_q.w3 <= gen_q.w1 ^ seed_v;
            step_q   <= '0;
            state_q  <= ST_ADVANCE;
          end else begin
            gen_q.w0 <= gen_q.w1 ^ seed_v;
            gen_q.w1 <= gen_q.w2;
            gen_q.w2 <= gen_q.w3;
            gen_q.w3 <= gen_q.w0;
            step_q   <= step_q + 3'd1;
            state_q  <= ST_SEED_MUL;
          end
        end
        ST_ADVANCE: begin
          gen_q <= tmt_pkg::advance(gen_q);
          if (step_q == tmt_pkg::StepLast) begin
            step_q  <= '0;
            state_q <= ST_TEMPER;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_TEMPER: begin
          word_q  <= tmt_pkg::temper(gen_q);
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          prod_q  <= mul_p;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {prod_q[63:32], word_q};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
